// ===== hw/rtl/spfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared sizes, codes and types of the string pool fit allocator.
// ----------------------------------------------------------------------------
package spfa_pkg;

    localparam int POOL_BYTES  = 65536;
    localparam int POOL_AW     = $clog2(POOL_BYTES);
    localparam int PTR_W       = POOL_AW + 1;
    localparam int FRAG_SLOTS  = 64;
    localparam int SLOT_W      = $clog2(FRAG_SLOTS);
    localparam int SCNT_W      = $clog2(FRAG_SLOTS + 1);
    localparam int FLD_W       = 16;
    localparam int PRELOAD_LEN = 13;
    localparam int INIT_W      = $clog2(PRELOAD_LEN + 1);

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_POOL_FULL = 2'd1;
    localparam logic [1:0] FAULT_TBL_FULL  = 2'd2;

    typedef struct packed {
        logic [PTR_W-1:0] start;
        logic [PTR_W-1:0] len;
    } t_frag;

    // Pool contents after reset: null, "<Not Found>", null.
    function automatic logic [7:0] preload_byte(input logic [INIT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            INIT_W'(1):  b = 8'h3C; // '<'
            INIT_W'(2):  b = 8'h4E; // 'N'
            INIT_W'(3):  b = 8'h6F;
            INIT_W'(4):  b = 8'h74;
            INIT_W'(5):  b = 8'h20;
            INIT_W'(6):  b = 8'h46;
            INIT_W'(7):  b = 8'h6F;
            INIT_W'(8):  b = 8'h75;
            INIT_W'(9):  b = 8'h6E;
            INIT_W'(10): b = 8'h64;
            INIT_W'(11): b = 8'h3E; // '>'
            default:     b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/spfa_pool_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_pool_ram
// Byte pool storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spfa_pool_ram
    import spfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [POOL_AW-1:0] i_waddr,
    input  logic [7:0]         i_wdata,
    input  logic [POOL_AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);

    logic [7:0] mem [POOL_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== hw/rtl/spfa_frag_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_frag_ram
// Free fragment table payload (start, length); validity lives outside.
// ----------------------------------------------------------------------------
module spfa_frag_ram
    import spfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_frag             i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_frag             o_rdata
);

    t_frag mem [FRAG_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== hw/rtl/string_pool_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_pool_fit_allocator
// Byte pool of null-terminated strings with exact/largest fit placement and
// coalescing of freed fragments, run by one sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  item in  | start & !busy          | i_operation, i_char_byte, i_first_of_string,
//           |                        | i_last_of_string, i_empty_string,
//           |                        | i_string_length, i_remove_start
//  result   | o_strobe (one cycle)   | o_placed_at, o_length_seen, o_done_kind,
//           |                        | o_fault
//
//  Steps per accepted item: an append byte passes through S_PUSH, and through
//  S_FIN as well when it closes the string. The first byte of a placed insert
//  adds a fragment table walk (S_FSCAN) and a placement step (S_PLACE). A
//  remove beyond the pool end, a remove while a string is open and an ignored
//  code are handled in S_IDLE alone. Any other remove walks the pool byte by
//  byte (S_RRD, S_RCK), the null included, and decides in S_RDEC; a string
//  that ends the pool finishes there, otherwise the fragment table walk and
//  an update step (S_RUPD) follow.
//  Reset: after i_rst_n the block writes the preloaded strings into the pool,
//  with busy high.
//  Results cannot be stalled: o_strobe is high for one cycle per result.
// ----------------------------------------------------------------------------
module string_pool_fit_allocator
    import spfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_operation,
    input  logic [7:0]       i_char_byte,
    input  logic             i_first_of_string,
    input  logic             i_last_of_string,
    input  logic             i_empty_string,
    input  logic [FLD_W-1:0] i_string_length,
    input  logic [FLD_W-1:0] i_remove_start,
    output logic             o_strobe,
    output logic [FLD_W-1:0] o_placed_at,
    output logic [FLD_W-1:0] o_length_seen,
    output logic [1:0]       o_done_kind,
    output logic [1:0]       o_fault
);

    localparam logic [PTR_W-1:0]  POOL_TOP  = PTR_W'(POOL_BYTES);
    localparam logic [PTR_W-1:0]  POOL_LAST = PTR_W'(POOL_BYTES - 1);
    localparam logic [PTR_W-1:0]  RESET_END = PTR_W'(PRELOAD_LEN);
    localparam logic [SCNT_W-1:0] SLOT_CNT  = SCNT_W'(FRAG_SLOTS);
    localparam logic [FLD_W-1:0]  LEN_CAP   = '1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FSCAN, S_PLACE, S_PUSH, S_FIN,
        S_RRD, S_RCK, S_RDEC, S_RUPD
    } t_state;

    t_state r_state;

    // latched item
    logic [7:0]       r_ch;
    logic             r_last;
    logic             r_empty;
    logic [FLD_W-1:0] r_want;
    logic [PTR_W-1:0] r_at;

    // string in progress
    logic [PTR_W-1:0] r_pool_end;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_sstart;
    logic [FLD_W-1:0] r_bytes;
    logic [FLD_W-1:0] r_limit;
    logic             r_str;
    logic [1:0]       r_kind;
    logic             r_grows;
    logic             r_ovf;

    // remove scan
    logic [PTR_W-1:0] r_c;
    logic [PTR_W-1:0] r_size;

    // fragment walk
    logic [SCNT_W-1:0]     r_idx;
    logic                  r_pv;
    logic [SLOT_W-1:0]     r_pidx;
    logic                  r_rm;
    logic [FRAG_SLOTS-1:0] r_valid;
    logic [INIT_W-1:0]     r_init;

    logic              r_ex_f, r_wd_f, r_fw_f, r_sm_f, r_bk_f, r_fr_f;
    logic [SLOT_W-1:0] r_ex_i, r_wd_i, r_fw_i, r_sm_i, r_bk_i, r_fr_i;
    logic [PTR_W-1:0]  r_ex_s, r_wd_s, r_wd_l, r_fw_l, r_bk_s, r_bk_l;

    // RAM ports
    logic               pool_we;
    logic [POOL_AW-1:0] pool_waddr;
    logic [7:0]         pool_wdata;
    logic [POOL_AW-1:0] pool_raddr;
    logic [7:0]         pool_rdata;
    logic               frag_we;
    logic [SLOT_W-1:0]  frag_waddr;
    t_frag              frag_wdata;
    logic [SLOT_W-1:0]  frag_raddr;
    t_frag              frag_rdata;

    logic             accept;
    logic [PTR_W-1:0] at_in;
    logic [PTR_W-1:0] want_x;
    logic [PTR_W-1:0] c_next;
    logic [PTR_W-1:0] total;
    logic [PTR_W:0]   frag_end;
    logic             push_ok;
    logic             has_slot;
    logic [SLOT_W-1:0] slot;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign at_in  = PTR_W'(i_remove_start);
    assign want_x = PTR_W'(r_want);
    assign c_next = r_c + PTR_W'(1);
    assign total  = r_size + (r_fw_f ? (r_fw_l + PTR_W'(1)) : '0);
    assign frag_end = {1'b0, frag_rdata.start} + {1'b0, frag_rdata.len} + (PTR_W + 1)'(1);
    assign push_ok  = !r_empty && (r_bytes < r_limit) && (r_wp < POOL_LAST);
    assign has_slot = r_fw_f || r_sm_f || r_fr_f;
    assign slot     = r_fw_f ? r_fw_i : (r_sm_f ? r_sm_i : r_fr_i);

    spfa_pool_ram u_pool (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_waddr (pool_waddr),
        .i_wdata (pool_wdata),
        .i_raddr (pool_raddr),
        .o_rdata (pool_rdata)
    );

    spfa_frag_ram u_frag (
        .i_clk   (i_clk),
        .i_we    (frag_we),
        .i_waddr (frag_waddr),
        .i_wdata (frag_wdata),
        .i_raddr (frag_raddr),
        .o_rdata (frag_rdata)
    );

    // RAM port steering
    always_comb begin
        pool_we    = 1'b0;
        pool_waddr = r_wp[POOL_AW-1:0];
        pool_wdata = r_ch;
        pool_raddr = r_c[POOL_AW-1:0];
        frag_we    = 1'b0;
        frag_waddr = r_bk_i;
        frag_wdata = '{start: r_bk_s, len: r_bk_l + total + PTR_W'(1)};
        frag_raddr = r_idx[SLOT_W-1:0];
        unique case (r_state)
            S_INIT: begin
                pool_we    = 1'b1;
                pool_waddr = POOL_AW'(r_init);
                pool_wdata = preload_byte(r_init);
            end
            S_PUSH: begin
                pool_we = push_ok;
            end
            S_FIN: begin
                pool_we    = (r_wp < POOL_TOP);
                pool_wdata = 8'h00;
            end
            S_PLACE: begin
                // shrink the chosen wide fragment to its remainder
                frag_we    = !r_ex_f && r_wd_f;
                frag_waddr = r_wd_i;
                frag_wdata = '{start: r_wd_s + want_x + PTR_W'(1),
                               len:   r_wd_l - want_x - PTR_W'(1)};
            end
            S_RUPD: begin
                if (r_bk_f) begin
                    frag_we = 1'b1;
                end else begin
                    frag_we    = has_slot;
                    frag_waddr = slot;
                    frag_wdata = '{start: r_at, len: total};
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= '0;
            r_pool_end <= RESET_END;
            r_valid    <= '0;
            r_str      <= 1'b0;
            r_wp       <= '0;
            r_sstart   <= '0;
            r_bytes    <= '0;
            r_pv       <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_init <= r_init + INIT_W'(1);
                    if (r_init == INIT_W'(PRELOAD_LEN - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (accept) begin
                        r_ch    <= i_char_byte;
                        r_last  <= i_last_of_string;
                        r_empty <= i_empty_string;
                        r_at    <= at_in;
                        case (i_operation) inside
                            OP_REMOVE: begin
                                // drop a remove while a string is open
                                if (!r_str) begin
                                    if (at_in >= r_pool_end) begin
                                        o_strobe      <= 1'b1;
                                        o_placed_at   <= i_remove_start;
                                        o_length_seen <= '0;
                                        o_done_kind   <= OP_REMOVE;
                                        o_fault       <= FAULT_NONE;
                                    end else begin
                                        r_c     <= at_in;
                                        r_size  <= '0;
                                        r_state <= S_RRD;
                                    end
                                end
                            end
                            OP_APPEND, OP_INSERT: begin
                                if (i_first_of_string || !r_str) begin
                                    r_str   <= 1'b1;
                                    r_kind  <= i_operation;
                                    r_bytes <= '0;
                                    r_ovf   <= 1'b0;
                                    r_grows <= 1'b1;
                                    if (i_operation == OP_INSERT) begin
                                        r_want  <= i_string_length;
                                        r_limit <= i_string_length;
                                        r_rm    <= 1'b0;
                                        r_idx   <= '0;
                                        r_pv    <= 1'b0;
                                        r_ex_f  <= 1'b0;
                                        r_wd_f  <= 1'b0;
                                        r_state <= S_FSCAN;
                                    end else begin
                                        r_limit  <= LEN_CAP;
                                        r_sstart <= r_pool_end;
                                        r_wp     <= r_pool_end;
                                        r_state  <= S_PUSH;
                                    end
                                end else begin
                                    r_state <= S_PUSH;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_FSCAN: begin
                    // issue one slot read a cycle, check it the cycle after
                    if (r_idx < SLOT_CNT) begin
                        r_idx  <= r_idx + SCNT_W'(1);
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[SLOT_W-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (!r_rm) begin
                            if (r_valid[r_pidx]) begin
                                if (frag_rdata.len == want_x) begin
                                    if (!r_ex_f || frag_rdata.start < r_ex_s) begin
                                        r_ex_f <= 1'b1;
                                        r_ex_i <= r_pidx;
                                        r_ex_s <= frag_rdata.start;
                                    end
                                end else if (frag_rdata.len > want_x) begin
                                    if (!r_wd_f || frag_rdata.len > r_wd_l ||
                                        (frag_rdata.len == r_wd_l &&
                                         frag_rdata.start < r_wd_s)) begin
                                        r_wd_f <= 1'b1;
                                        r_wd_i <= r_pidx;
                                        r_wd_s <= frag_rdata.start;
                                        r_wd_l <= frag_rdata.len;
                                    end
                                end
                            end
                        end else begin
                            if (r_valid[r_pidx]) begin
                                if (!r_fw_f && frag_rdata.start == c_next) begin
                                    r_fw_f <= 1'b1;
                                    r_fw_i <= r_pidx;
                                    r_fw_l <= frag_rdata.len;
                                end
                                if (!r_sm_f && frag_rdata.start == r_at) begin
                                    r_sm_f <= 1'b1;
                                    r_sm_i <= r_pidx;
                                end
                                if (!r_bk_f && frag_end == {1'b0, r_at}) begin
                                    r_bk_f <= 1'b1;
                                    r_bk_i <= r_pidx;
                                    r_bk_s <= frag_rdata.start;
                                    r_bk_l <= frag_rdata.len;
                                end
                            end else if (!r_fr_f) begin
                                r_fr_f <= 1'b1;
                                r_fr_i <= r_pidx;
                            end
                        end
                    end
                    if (r_idx == SLOT_CNT && !r_pv) begin
                        r_state <= r_rm ? S_RUPD : S_PLACE;
                    end
                end

                S_PLACE: begin
                    if (r_ex_f) begin
                        r_sstart         <= r_ex_s;
                        r_wp             <= r_ex_s;
                        r_valid[r_ex_i]  <= 1'b0;
                        r_grows          <= 1'b0;
                    end else if (r_wd_f) begin
                        r_sstart <= r_wd_s;
                        r_wp     <= r_wd_s;
                        r_grows  <= 1'b0;
                    end else begin
                        r_sstart <= r_pool_end;
                        r_wp     <= r_pool_end;
                    end
                    r_state <= S_PUSH;
                end

                S_PUSH: begin
                    if (!r_empty) begin
                        if (r_bytes >= r_limit) begin
                            // appends flag the overrun, inserts drop silently
                            if (r_kind == OP_APPEND) begin
                                r_ovf <= 1'b1;
                            end
                        end else if (r_wp >= POOL_LAST) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_wp    <= r_wp + PTR_W'(1);
                            r_bytes <= r_bytes + FLD_W'(1);
                        end
                    end
                    r_state <= r_last ? S_FIN : S_IDLE;
                end

                S_FIN: begin
                    if (r_wp < POOL_TOP && r_grows) begin
                        r_pool_end <= r_wp + PTR_W'(1);
                    end
                    r_str         <= 1'b0;
                    o_strobe      <= 1'b1;
                    o_placed_at   <= r_sstart[FLD_W-1:0];
                    o_length_seen <= r_bytes;
                    o_done_kind   <= r_kind;
                    o_fault       <= (r_ovf || r_wp >= POOL_TOP) ? FAULT_POOL_FULL
                                                                 : FAULT_NONE;
                    r_state       <= S_IDLE;
                end

                S_RRD: begin
                    r_state <= (r_c >= r_pool_end) ? S_RDEC : S_RCK;
                end

                S_RCK: begin
                    if (pool_rdata == 8'h00) begin
                        r_state <= S_RDEC;
                    end else begin
                        r_c     <= c_next;
                        r_size  <= r_size + PTR_W'(1);
                        r_state <= S_RRD;
                    end
                end

                S_RDEC: begin
                    if (c_next >= r_pool_end) begin
                        // string ends the pool: cut the end back
                        r_pool_end    <= r_at;
                        o_strobe      <= 1'b1;
                        o_placed_at   <= r_at[FLD_W-1:0];
                        o_length_seen <= r_size[FLD_W-1:0];
                        o_done_kind   <= OP_REMOVE;
                        o_fault       <= FAULT_NONE;
                        r_state       <= S_IDLE;
                    end else begin
                        r_rm    <= 1'b1;
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_fw_f  <= 1'b0;
                        r_sm_f  <= 1'b0;
                        r_bk_f  <= 1'b0;
                        r_fr_f  <= 1'b0;
                        r_state <= S_FSCAN;
                    end
                end

                S_RUPD: begin
                    o_strobe      <= 1'b1;
                    o_placed_at   <= r_at[FLD_W-1:0];
                    o_length_seen <= r_size[FLD_W-1:0];
                    o_done_kind   <= OP_REMOVE;
                    o_fault       <= FAULT_NONE;
                    if (r_bk_f) begin
                        // grow the fragment behind; absorb the one ahead
                        if (r_fw_f) begin
                            r_valid[r_fw_i] <= 1'b0;
                        end
                        if (r_sm_f) begin
                            r_valid[r_sm_i] <= 1'b0;
                        end
                    end else begin
                        if (r_fw_f && r_sm_f) begin
                            r_valid[r_sm_i] <= 1'b0;
                        end
                        if (has_slot) begin
                            r_valid[slot] <= 1'b1;
                        end else begin
                            o_fault <= FAULT_TBL_FULL;
                        end
                    end
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
